/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* hdl/ssb_pkg.sv */
package ssb_pkg;

   localparam int PATTERN_MAX = 16;
   localparam int TEXT_MAX    = 65535;

   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 5;
   localparam int COUNT_W = 16;
   localparam int POS_W   = 17;
   localparam int CSR_W   = 64;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_PATTERN_LEN  = 3'd2,
      CSR_START_POS    = 3'd3,
      CSR_DIRECTION    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_FOUND = 2'd0,
      ST_NONE  = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   typedef logic [PATTERN_MAX*BYTE_W-1:0] pattern_type;

   typedef struct packed {
      logic step;    // nonzero text byte in the execute stage
      logic finish;  // terminator in the execute stage
   } beat_ctl_type;

   typedef struct packed {
      status_type           status;
      logic [COUNT_W-1:0]   index;
   } result_type;

endpackage

/* hdl/ssb_window.sv */
module ssb_window (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       shift,
   input  logic                       clear,
   input  logic [ssb_pkg::BYTE_W-1:0] text_byte,
   input  ssb_pkg::pattern_type       pattern,
   input  logic [ssb_pkg::LEN_W-1:0]  len_used,
   output logic                       hit
);
   import ssb_pkg::*;

   logic [BYTE_W-1:0]    window_ff  [PATTERN_MAX];
   logic [BYTE_W-1:0]    window_in  [PATTERN_MAX];
   logic [BYTE_W-1:0]    pat_byte   [PATTERN_MAX];
   logic [PATTERN_MAX:0] hit_by_len;

   always_comb begin
      window_in[0] = text_byte;
      for (int i = 1; i < PATTERN_MAX; i++) begin
         window_in[i] = window_ff[i-1];
      end
      for (int j = 0; j < PATTERN_MAX; j++) begin
         pat_byte[j] = pattern[BYTE_W*j +: BYTE_W];
      end
   end

   // Compare the shifted window against every pattern length in parallel:
   // newest byte lines up with the last pattern byte.
   always_comb begin
      hit_by_len = '0;
      for (int l = 1; l <= PATTERN_MAX; l++) begin
         hit_by_len[l] = 1'b1;
         for (int i = 0; i < l; i++) begin
            if (window_in[i] != pat_byte[l-1-i]) begin
               hit_by_len[l] = 1'b0;
            end
         end
      end
   end

   assign hit = hit_by_len[len_used];

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < PATTERN_MAX; i++) begin
            window_ff[i] <= '0;
         end
      end else if (shift) begin
         window_ff <= window_in;
      end
   end

endmodule

/* hdl/ssb_track.sv */
module ssb_track (
   input  logic                              clock,
   input  logic                              reset,
   input  ssb_pkg::beat_ctl_type             ctl,
   input  logic                              hit,
   input  logic [ssb_pkg::LEN_W-1:0]         len_used,
   input  logic signed [ssb_pkg::POS_W-1:0]  start_pos,
   input  logic                              forward,
   output logic                              shift,
   output ssb_pkg::result_type               result
);
   import ssb_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               overflow_ff, overflow_in;
   logic               have_ff, have_in;
   logic [COUNT_W-1:0] best_ff, best_in;

   logic               at_limit;
   logic [COUNT_W-1:0] count_inc;
   logic [COUNT_W-1:0] len_ext;
   logic [COUNT_W-1:0] match_start;
   logic               qualify;
   logic               fwd_ok;
   logic               bwd_ok;

   assign at_limit    = overflow_ff || (count_ff == COUNT_W'(TEXT_MAX));
   assign shift       = ctl.step && !at_limit;
   assign count_inc   = count_ff + COUNT_W'(1);
   assign len_ext     = {{(COUNT_W-LEN_W){1'b0}}, len_used};
   assign match_start = count_inc - len_ext;
   assign qualify     = hit && (len_used != '0) && (count_inc >= len_ext);
   assign fwd_ok      = start_pos[POS_W-1] || (match_start >= start_pos[COUNT_W-1:0]);
   assign bwd_ok      = !start_pos[POS_W-1] && (match_start <= start_pos[COUNT_W-1:0]);

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      have_in     = have_ff;
      best_in     = best_ff;
      if (ctl.finish) begin
         count_in    = '0;
         overflow_in = 1'b0;
         have_in     = 1'b0;
         best_in     = '0;
      end else if (ctl.step) begin
         if (at_limit) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_inc;
            if (qualify) begin
               // forward keeps the first qualifying start, backward the last
               if (forward) begin
                  if (!have_ff && fwd_ok) begin
                     have_in = 1'b1;
                     best_in = match_start;
                  end
               end else if (bwd_ok) begin
                  have_in = 1'b1;
                  best_in = match_start;
               end
            end
         end
      end
   end

   always_comb begin
      result.status = ST_NONE;
      result.index  = '0;
      priority if (overflow_ff || (count_ff < len_ext)) begin
         result.status = ST_ERROR;
      end else if (count_ff == '0) begin
         result.status = ST_FOUND;
      end else if (len_used == '0) begin
         result.status = ST_FOUND;
         result.index  = count_ff;
      end else if (forward && (start_pos >= $signed({1'b0, count_ff}))) begin
         result.status = ST_ERROR;
      end else if (!forward && start_pos[POS_W-1]) begin
         result.status = ST_ERROR;
      end else if (have_ff) begin
         result.status = ST_FOUND;
         result.index  = best_ff;
      end else begin
         result.status = ST_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         have_ff     <= 1'b0;
         best_ff     <= '0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         have_ff     <= have_in;
         best_ff     <= best_in;
      end
   end

endmodule

/* hdl/substring_search_bidirectional_core.sv */
// A terminator beat waits in the execute stage register, then its result is loaded into the result register.
// Throughput: one text byte per cycle; the input register keeps taking beats
// while a finished result waits in the output register, and only a second
// terminator stalls behind an unread result.
// Reset (synchronous, active high) restores register defaults (forward
// direction, everything else zero) and clears the window and text state.
`include "assert_macros.svh"

module substring_search_bidirectional_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ssb_pkg::BYTE_W-1:0]     req_text_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [ssb_pkg::COUNT_W-1:0]    rsp_match_index,
   input  logic                           csr_write_enable,
   input  logic [ssb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssb_pkg::CSR_W-1:0]      csr_write_data
);
   import ssb_pkg::*;

   // configuration registers
   logic [CSR_W-1:0]        pat_low_ff;
   logic [CSR_W-1:0]        pat_high_ff;
   logic [LEN_W-1:0]        pat_len_ff;
   logic signed [POS_W-1:0] start_pos_ff;
   logic                    forward_ff;

   // execute stage
   logic                    s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0]       s1_byte_ff;
   logic                    s1_advance;
   logic                    s1_terminator;
   logic                    s1_fire;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_ff;

   beat_ctl_type            ctl;
   logic [LEN_W-1:0]        len_used;
   logic                    hit;
   logic                    shift;
   result_type              result;

   assign len_used = (pat_len_ff > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_ff;

   assign s1_terminator = (s1_byte_ff == '0);
   // only a terminator needs room in the result register
   assign s1_advance    = !s1_terminator || !rsp_valid_ff || rsp_ready;
   assign s1_fire       = s1_valid_ff && s1_advance;
   assign req_ready     = !s1_valid_ff || s1_advance;

   assign ctl.step   = s1_fire && !s1_terminator;
   assign ctl.finish = s1_fire && s1_terminator;

   assign s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = ctl.finish || (rsp_valid_ff && !rsp_ready);

   ssb_window u_window (
      .clock     (clock),
      .reset     (reset),
      .shift     (shift),
      .clear     (ctl.finish),
      .text_byte (s1_byte_ff),
      .pattern   ({pat_high_ff, pat_low_ff}),
      .len_used  (len_used),
      .hit       (hit)
   );

   ssb_track u_track (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .hit       (hit),
      .len_used  (len_used),
      .start_pos (start_pos_ff),
      .forward   (forward_ff),
      .shift     (shift),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff   <= '0;
         pat_high_ff  <= '0;
         pat_len_ff   <= '0;
         start_pos_ff <= '0;
         forward_ff   <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  pat_low_ff   <= csr_write_data;
            CSR_PATTERN_HIGH: pat_high_ff  <= csr_write_data;
            CSR_PATTERN_LEN:  pat_len_ff   <= csr_write_data[LEN_W-1:0];
            CSR_START_POS:    start_pos_ff <= $signed(csr_write_data[POS_W-1:0]);
            CSR_DIRECTION:    forward_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the byte until it moves on; load the result on a terminator
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_text_byte;
      end
      if (ctl.finish) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_match_index = rsp_ff.index;

   `ASSERT_NEXT(a_term_gives_result, clock, reset, ctl.finish, rsp_valid_ff)
   `ASSERT_IMPLY(a_stall_only_on_full, clock, reset, !req_ready,
      s1_valid_ff && s1_terminator && rsp_valid_ff && !rsp_ready)
   `ASSERT_IMPLY(a_no_index_on_miss, clock, reset,
      rsp_valid_ff && (rsp_ff.status != ST_FOUND), rsp_ff.index == '0)
   `ASSERT_IMPLY(a_step_finish_excl, clock, reset, ctl.step || ctl.finish,
      s1_fire && !(ctl.step && ctl.finish))

endmodule
